FILE: rtl/glyph_rle_palette_decoder_macros.svh
// Assertion helpers for the glyph decoder. Each checks on the rising edge of
// clock and stays quiet while reset is high.
`ifndef GLYPH_RLE_PALETTE_DECODER_MACROS_SVH
`define GLYPH_RLE_PALETTE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define GRPD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grpd assertion failed");

// antecedent implies consequent in the next cycle
`define GRPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("grpd assertion failed");

`else

`define GRPD_ASSERT_SAME(label, ante, cons)
`define GRPD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/grpd_pkg.sv
`timescale 1ns / 1ps

package grpd_pkg;

   // colour translation table size
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

   // item kinds
   localparam logic REQ_TABLE_WRITE = 1'b0;
   localparam logic REQ_DATA_BYTE = 1'b1;

   // stream constants
   localparam logic [7:0] SKIP_CODE = 8'h80;
   localparam logic [8:0] REPEAT_BASE = 9'h101;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LITERAL = 2'd1,
      PH_REPEAT = 2'd2
   } decode_phase_type;

   typedef struct packed {
      logic req_type;
      logic [7:0] table_index;
      logic [7:0] table_value;
      logic [7:0] data_byte;
      logic [15:0] glyph_pixels;
   } grpd_req_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic [7:0] run_length;
      logic glyph_end;
      logic overrun;
   } grpd_rsp_type;

   // run descriptor held in the result register, minus the pixel value
   typedef struct packed {
      logic valid;
      logic [7:0] run_length;
      logic glyph_end;
      logic overrun;
   } grpd_run_type;

endpackage

FILE: rtl/grpd_ctab.sv
`timescale 1ns / 1ps

module grpd_ctab
   import grpd_pkg::*;
(
   input logic clock,
   input logic accept,
   input grpd_req_type req,
   output logic [7:0] pixel_value
);

   logic [7:0] table_mem [PALETTE_ENTRIES];
   logic [7:0] rd_data_ff;
   logic out_of_range_ff;
   logic wr_in_range;
   logic rd_in_range;

   assign wr_in_range = {1'b0, req.table_index} < PAL_LIMIT;
   assign rd_in_range = {1'b0, req.data_byte} < PAL_LIMIT;

   always_ff @(posedge clock) begin
      if (accept && (req.req_type == REQ_TABLE_WRITE) && wr_in_range) begin
         table_mem[req.table_index[PAL_IDX_W-1:0]] <= req.table_value;
      end
      // read data holds while the result waits downstream
      if (accept && (req.req_type == REQ_DATA_BYTE)) begin
         rd_data_ff <= table_mem[req.data_byte[PAL_IDX_W-1:0]];
         out_of_range_ff <= !rd_in_range;
      end
   end

   assign pixel_value = out_of_range_ff ? 8'd0 : rd_data_ff;

endmodule

FILE: rtl/grpd_ctrl.sv
`timescale 1ns / 1ps

`include "glyph_rle_palette_decoder_macros.svh"

module grpd_ctrl
   import grpd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic accept,
   input logic rsp_stall,
   input grpd_req_type req,
   output grpd_run_type run
);

   decode_phase_type phase_ff, phase_in;
   logic [7:0] lit_ff, lit_in;
   logic [7:0] rep_ff, rep_in;
   logic [15:0] px_ff, px_in;
   grpd_run_type run_ff, run_in;

   logic emit;
   logic [7:0] len_w;
   logic end_w;
   logic over_w;
   logic [7:0] lit_dec;
   logic [15:0] px_dec;
   logic [15:0] rep_ext;
   logic rep_cut;
   logic [15:0] px_sub;
   logic [8:0] rep_diff;

   assign lit_dec = lit_ff - 8'd1;
   assign px_dec = px_ff - 16'd1;
   assign rep_ext = {8'd0, rep_ff};
   assign rep_cut = rep_ext > px_ff;
   assign px_sub = px_ff - (rep_cut ? px_ff : rep_ext);
   assign rep_diff = REPEAT_BASE - {1'b0, req.data_byte};

   always_comb begin
      phase_in = phase_ff;
      lit_in = lit_ff;
      rep_in = rep_ff;
      px_in = px_ff;
      emit = 1'b0;
      len_w = 8'd1;
      end_w = 1'b0;
      over_w = 1'b0;
      if (accept && (req.req_type == REQ_DATA_BYTE)) begin
         unique case (phase_ff)
            PH_LITERAL: begin
               lit_in = lit_dec;
               if (lit_dec == 8'd0) begin
                  phase_in = PH_HEADER;
               end
               // tail bytes of a cut literal run are swallowed
               if (px_ff != 16'd0) begin
                  px_in = px_dec;
                  emit = 1'b1;
                  end_w = (px_dec == 16'd0);
                  over_w = (px_dec == 16'd0) && (lit_dec != 8'd0);
               end
            end
            PH_REPEAT: begin
               phase_in = PH_HEADER;
               if (px_ff != 16'd0) begin
                  px_in = px_sub;
                  emit = 1'b1;
                  len_w = rep_cut ? px_ff[7:0] : rep_ff;
                  end_w = (px_sub == 16'd0);
                  over_w = rep_cut;
               end
            end
            default: begin
               if (px_ff == 16'd0) begin
                  px_in = (req.glyph_pixels == 16'd0) ? 16'd1 : req.glyph_pixels;
               end
               if (req.data_byte < SKIP_CODE) begin
                  lit_in = req.data_byte + 8'd1;
                  phase_in = PH_LITERAL;
               end else if (req.data_byte > SKIP_CODE) begin
                  rep_in = rep_diff[7:0];
                  phase_in = PH_REPEAT;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   always_comb begin
      run_in = run_ff;
      if (accept) begin
         run_in.valid = emit;
         run_in.run_length = len_w;
         run_in.glyph_end = end_w;
         run_in.overrun = over_w;
      end else if (!rsp_stall) begin
         run_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         lit_ff <= 8'd0;
         rep_ff <= 8'd0;
         px_ff <= 16'd0;
         run_ff.valid <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         lit_ff <= lit_in;
         rep_ff <= rep_in;
         px_ff <= px_in;
         run_ff.valid <= run_in.valid;
      end
      run_ff.run_length <= run_in.run_length;
      run_ff.glyph_end <= run_in.glyph_end;
      run_ff.overrun <= run_in.overrun;
   end

   assign run = run_ff;

   `GRPD_ASSERT_SAME(a_over_ends_glyph, run_ff.valid && run_ff.overrun, run_ff.glyph_end)
   `GRPD_ASSERT_SAME(a_len_range, run_ff.valid,
      (run_ff.run_length != 8'd0) && (run_ff.run_length <= 8'd128))
   `GRPD_ASSERT_SAME(a_literal_pending, phase_ff == PH_LITERAL, lit_ff != 8'd0)
   `GRPD_ASSERT_SAME(a_repeat_has_glyph, phase_ff == PH_REPEAT,
      (px_ff != 16'd0) && (rep_ff >= 8'd2))
   `GRPD_ASSERT_NEXT(a_end_clears_count, accept && emit && end_w, px_ff == 16'd0)

endmodule

FILE: rtl/glyph_rle_palette_decoder.sv
`timescale 1ns / 1ps

// channel  | valid     | stall     | payload
// ---------+-----------+-----------+----------------------------------------
// request  | req_valid | req_stall | req_payload (table write or data byte)
// result   | rsp_valid | rsp_stall | rsp_payload (translated run)
//
// One item per cycle while req_stall is low; a result is shown the
// cycle after its data byte was taken, from the result register and the
// colour table's registered read port.
// Synchronous reset clears the decode state and the result valid bit; the
// colour table is not cleared and must be written before use.
// req_stall is high only while a result is held and rsp_stall is high.

module glyph_rle_palette_decoder
   import grpd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input grpd_req_type req_payload,
   output logic rsp_valid,
   input logic rsp_stall,
   output grpd_rsp_type rsp_payload
);

   logic accept;
   grpd_run_type run;
   logic [7:0] pixel_value;

   assign req_stall = run.valid && rsp_stall;
   assign accept = req_valid && !req_stall;

   grpd_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rsp_stall(rsp_stall),
      .req(req_payload),
      .run(run)
   );

   grpd_ctab u_ctab (
      .clock(clock),
      .accept(accept),
      .req(req_payload),
      .pixel_value(pixel_value)
   );

   assign rsp_valid = run.valid;
   assign rsp_payload.pixel_value = pixel_value;
   assign rsp_payload.run_length = run.run_length;
   assign rsp_payload.glyph_end = run.glyph_end;
   assign rsp_payload.overrun = run.overrun;

endmodule
